@@ src/text_console_char_writer_core_defines.svh @@
// assertion macros for the text console character writer
// no dependencies; included by the files that carry assertions
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, quiet while reset is asserted
`define TCW_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error(msg);
// clocked check that also holds during reset
`define TCW_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk_i, rst_n_i, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, clk_i, prop, msg)
`endif
`endif

@@ src/tcw_pkg.sv @@
// shared types and constants for the text console character writer
// no dependencies
package tcw_pkg;

	// default screen geometry
	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;

	// character and attribute codes
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic wrap_clear;
		logic clr_last;
	} ctrl_stat_t;

endpackage

@@ src/text_console_char_writer_core.sv @@
// top level of the text console character writer
// depends on tcw_pkg, tcw_ctrl, tcw_datapath and the assertion macro header

// Each command (put or read) is accepted when start is high and busy is low, and its
// single result beat appears on the result ports, marked by done, in the very next
// cycle; a new command may be issued every cycle while busy is low. The receiver
// cannot stall: capture every beat on the cycle done is high. After reset, and after
// any put that blanks the screen (screen_cleared set), busy stays high while a sweep
// writes a space into every cell of the character memory, one cell per cycle through
// its single write port. Attribute bytes are never written by puts and read as 0x07
// for every cell in range.
`include "text_console_char_writer_core_defines.svh"

module text_console_char_writer_core
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLS = DEF_COLS,
	parameter int SCREEN_ROWS = DEF_ROWS,
	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS,
	localparam int COL_W = $clog2(SCREEN_COLS),
	localparam int ROW_W = $clog2(SCREEN_ROWS),
	localparam int IDX_W = $clog2(CELLS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             operation,
	input  logic [7:0]       char_code,
	input  logic [IDX_W-1:0] read_index,
	output logic             done,
	output logic [COL_W-1:0] cursor_col,
	output logic [ROW_W-1:0] cursor_row,
	output logic [IDX_W-1:0] cell_index,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attr,
	output logic             screen_cleared
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// sequencing
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// cursor, memory and result beat
	tcw_datapath #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.operation      (operation),
		.char_code      (char_code),
		.read_index     (read_index),
		.done           (done),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.cell_index     (cell_index),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr),
		.screen_cleared (screen_cleared)
	);

	// every accepted command gives a beat in the next cycle, and only then
	`TCW_ASSERT(a_beat_follows_accept, clk, arst_n, (start && !busy) |=> done, "missing result beat")
	`TCW_ASSERT(a_beat_has_accept, clk, arst_n, done |-> $past(start && !busy), "spurious result beat")
	// a clearing beat reports the homed cursor while the sweep runs
	`TCW_ASSERT(a_clear_homes, clk, arst_n, (done && screen_cleared) |-> (cursor_col == '0 && cursor_row == '0), "cursor not homed after clear")
	`TCW_ASSERT(a_clear_sweeps, clk, arst_n, (done && screen_cleared) |-> busy, "no sweep after clear")
	// no beat can be in flight while reset holds
	`TCW_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!done && busy), "activity during reset")

endmodule

@@ src/tcw_ctrl.sv @@
// controller for the text console character writer: run / clear sequencing
// depends on tcw_pkg
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	// state register, reset begins with a clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.clr_step = 1'b0;
		busy         = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				busy       = 1'b0;
				cmd.accept = start;
				if (start && stat.wrap_clear) begin
					state_d = ST_CLEAR;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

@@ src/tcw_datapath.sv @@
// datapath for the text console character writer: cursor, character memory, result
// depends on tcw_pkg
module tcw_datapath
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLS = DEF_COLS,
	parameter int SCREEN_ROWS = DEF_ROWS,
	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS,
	localparam int COL_W = $clog2(SCREEN_COLS),
	localparam int ROW_W = $clog2(SCREEN_ROWS),
	localparam int IDX_W = $clog2(CELLS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output ctrl_stat_t       stat,
	input  logic             operation,
	input  logic [7:0]       char_code,
	input  logic [IDX_W-1:0] read_index,
	output logic             done,
	output logic [COL_W-1:0] cursor_col,
	output logic [ROW_W-1:0] cursor_row,
	output logic [IDX_W-1:0] cell_index,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attr,
	output logic             screen_cleared
);

	logic [7:0]       char_mem [CELLS];
	logic [7:0]       rd_data_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [IDX_W-1:0] base_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             done_q;

	logic [IDX_W-1:0] res_idx_q;
	logic [7:0]       res_char_q;
	logic [7:0]       res_attr_q;
	logic             res_clr_q;
	logic             rd_sel_q;
	logic             in_range_q;

	logic             is_put;
	logic             is_nl;
	logic             col_last;
	logic             row_last;
	logic             adv_row;
	logic             wrap_clear;
	logic             in_range;
	logic             mem_we;
	logic [IDX_W-1:0] put_idx;

	// decode the item and the cursor position
	always_comb begin
		is_put     = (operation == OP_PUT);
		is_nl      = (char_code == NEWLINE_CODE);
		col_last   = (col_q == COL_W'(SCREEN_COLS - 1));
		row_last   = (row_q == ROW_W'(SCREEN_ROWS - 1));
		adv_row    = is_nl || col_last;
		wrap_clear = is_put && adv_row && row_last;
		in_range   = (read_index <= IDX_W'(CELLS - 1));
		put_idx    = base_q + IDX_W'(col_q);
		mem_we     = cmd.accept && is_put && !is_nl && !wrap_clear;
	end

	assign stat.wrap_clear = wrap_clear;
	assign stat.clr_last   = (clr_idx_q == IDX_W'(CELLS - 1));

	// cursor, row base, sweep counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			base_q    <= '0;
			clr_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.accept;
			if (cmd.clr_step) begin
				clr_idx_q <= stat.clr_last ? '0 : clr_idx_q + 1'b1;
			end
			if (cmd.accept && is_put) begin
				if (wrap_clear) begin
					col_q  <= '0;
					row_q  <= '0;
					base_q <= '0;
				end else if (adv_row) begin
					col_q  <= '0;
					row_q  <= row_q + 1'b1;
					base_q <= base_q + IDX_W'(SCREEN_COLS);
				end else begin
					col_q  <= col_q + 1'b1;
				end
			end
		end
	end

	// result payload for the beat that follows acceptance
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_sel_q   <= !is_put;
			in_range_q <= in_range;
			res_clr_q  <= wrap_clear;
			if (!is_put) begin
				res_idx_q  <= read_index;
				res_char_q <= 8'h00;
				res_attr_q <= in_range ? RESET_ATTR : 8'h00;
			end else if (is_nl) begin
				res_idx_q  <= '0;
				res_char_q <= 8'h00;
				res_attr_q <= 8'h00;
			end else begin
				res_idx_q  <= put_idx;
				res_char_q <= wrap_clear ? BLANK_CHAR : char_code;
				res_attr_q <= RESET_ATTR;
			end
		end
	end

	// character memory: sweep writes blanks, puts write at the cursor
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			char_mem[clr_idx_q] <= BLANK_CHAR;
		end else if (mem_we) begin
			char_mem[put_idx] <= char_code;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (cmd.accept && !is_put && in_range) begin
			rd_data_q <= char_mem[read_index];
		end
	end

	assign done           = done_q;
	assign cursor_col     = col_q;
	assign cursor_row     = row_q;
	assign cell_index     = res_idx_q;
	assign cell_char      = rd_sel_q ? (in_range_q ? rd_data_q : 8'h00) : res_char_q;
	assign cell_attr      = res_attr_q;
	assign screen_cleared = res_clr_q;

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for text_console_char_writer_core: puts and reads with random
// gaps, checked beat by beat against a cycle-free model of the console screen
// depends on tcw_pkg and the core rtl
module tb;
	import tcw_pkg::*;

	localparam int COLS  = DEF_COLS;
	localparam int ROWS  = DEF_ROWS;
	localparam int CELLS = COLS * ROWS;

	typedef struct {
		op_t        op;
		logic [7:0] code;
		logic [10:0] ridx;
		int         gap;
		bit         drain;
	} console_cmd_t;

	typedef struct {
		logic [6:0]  col;
		logic [4:0]  row;
		logic [10:0] idx;
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic        clr;
	} cell_report_t;

	logic        clk;
	logic        arst_n = 1'b1;
	logic        start = 1'b0;
	logic        operation = OP_PUT;
	logic [7:0]  char_code = 8'h00;
	logic [10:0] read_index = 11'd0;
	logic        busy;
	logic        done;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [10:0] cell_index;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;
	logic        screen_cleared;

	// model screen state
	logic [7:0] scr_char [CELLS];
	logic [7:0] scr_attr [CELLS];
	int         cur_col;
	int         cur_row;

	// cursor as seen while planning the stimulus
	int plan_col;
	int plan_row;
	bit drain_next;

	console_cmd_t  cmd_q[$];
	cell_report_t  pending_reports[$];
	console_cmd_t  cmd;
	cell_report_t  want;
	int            idle_cnt = 0;
	int            err_cnt = 0;

	text_console_char_writer_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.char_code      (char_code),
		.read_index     (read_index),
		.done           (done),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.cell_index     (cell_index),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr),
		.screen_cleared (screen_cleared)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timeout
	initial begin
		#(8 * 4000000);
		$display("DONE: errors detected");
		$finish;
	end

	// apply one command to the model screen and return the beat it should produce
	function automatic cell_report_t advance_console(op_t op, logic [7:0] code,
		logic [10:0] ridx);
		cell_report_t r;
		int pos;
		bit wrote;
		r.idx = '0;
		r.ch = '0;
		r.attr = '0;
		r.clr = 1'b0;
		pos = 0;
		wrote = 1'b0;
		if (op == OP_READ) begin
			r.idx = ridx;
			if (ridx < CELLS) begin
				r.ch = scr_char[ridx];
				r.attr = scr_attr[ridx];
			end
		end else begin
			if (code == NEWLINE_CODE) begin
				cur_row++;
				cur_col = 0;
			end else begin
				pos = cur_row * COLS + cur_col;
				if (pos >= CELLS)
					pos = 0;
				scr_char[pos] = code;
				wrote = 1'b1;
				cur_col++;
			end
			if (cur_col >= COLS) begin
				cur_col = 0;
				cur_row++;
			end
			// ran off the bottom: blank characters, keep attributes, home cursor
			if (cur_row >= ROWS) begin
				foreach (scr_char[i])
					scr_char[i] = BLANK_CHAR;
				cur_col = 0;
				cur_row = 0;
				r.clr = 1'b1;
			end
			if (wrote) begin
				r.idx = 11'(pos);
				r.ch = scr_char[pos];
				r.attr = scr_attr[pos];
			end
		end
		r.col = 7'(cur_col);
		r.row = 5'(cur_row);
		return r;
	endfunction

	// idle length between commands: mostly none or short, a few long
	function automatic int pick_gap(bit tight);
		int r;
		if (tight)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_cmd(op_t op, logic [7:0] code, logic [10:0] ridx, int gap);
		console_cmd_t c;
		c.op = op;
		c.code = code;
		c.ridx = ridx;
		c.gap = gap;
		c.drain = drain_next;
		drain_next = 1'b0;
		cmd_q.push_back(c);
		// keep the planning cursor in step with puts
		if (op == OP_PUT) begin
			if (code == NEWLINE_CODE) begin
				plan_row++;
				plan_col = 0;
			end else begin
				plan_col++;
			end
			if (plan_col >= COLS) begin
				plan_col = 0;
				plan_row++;
			end
			if (plan_row >= ROWS) begin
				plan_col = 0;
				plan_row = 0;
			end
		end
	endtask

	function automatic logic [7:0] pick_char(bit allow_nl);
		int r;
		r = $urandom_range(0, 99);
		if (allow_nl && r < 12)
			return NEWLINE_CODE;
		if (r < 22)
			return 8'($urandom_range(128, 255));
		if (r < 27)
			return allow_nl ? 8'($urandom_range(0, 31)) : 8'($urandom_range(11, 31));
		return 8'($urandom_range(32, 126));
	endfunction

	// walk to the bottom row, then either fill it to its last cell or newline off it
	task automatic queue_screen_tail(bit by_newline, bit tight);
		while (plan_row != ROWS - 1 || plan_col != 0)
			queue_cmd(OP_PUT, NEWLINE_CODE, 11'($urandom_range(0, 2047)), pick_gap(tight));
		if (by_newline) begin
			repeat ($urandom_range(1, 20))
				queue_cmd(OP_PUT, pick_char(1'b0), '0, pick_gap(tight));
			queue_cmd(OP_PUT, NEWLINE_CODE, '0, pick_gap(tight));
		end else begin
			repeat (COLS)
				queue_cmd(OP_PUT, pick_char(1'b0), '0, pick_gap(tight));
		end
	endtask

	// stimulus, reset and end of run
	initial begin
		int kind;
		int r;
		bit tight;
		foreach (scr_char[i]) begin
			scr_char[i] = BLANK_CHAR;
			scr_attr[i] = RESET_ATTR;
		end
		cur_col = 0;
		cur_row = 0;
		plan_col = 0;
		plan_row = 0;
		drain_next = 1'b0;

		// directed: reset contents, range edges, character extremes
		queue_cmd(OP_READ, 8'h00, 11'd0, 0);
		queue_cmd(OP_READ, 8'hFF, 11'd1999, 0);
		queue_cmd(OP_READ, 8'h00, 11'd2000, 1);
		queue_cmd(OP_READ, 8'h00, 11'd2047, 0);
		queue_cmd(OP_PUT, 8'h41, 11'd2047, 0);
		queue_cmd(OP_PUT, 8'h00, 11'd0, 2);
		queue_cmd(OP_PUT, 8'hFF, 11'd0, 0);
		queue_cmd(OP_PUT, 8'h80, 11'd0, 0);
		queue_cmd(OP_PUT, 8'h7F, 11'd0, 0);
		queue_cmd(OP_PUT, NEWLINE_CODE, 11'd0, 0);
		queue_cmd(OP_PUT, NEWLINE_CODE, 11'd0, 3);
		queue_cmd(OP_PUT, 8'h5A, 11'd0, 0);
		queue_cmd(OP_READ, 8'h00, 11'd0, 0);
		queue_cmd(OP_READ, 8'h00, 11'd1, 0);
		queue_cmd(OP_READ, 8'h00, 11'd2, 0);
		queue_cmd(OP_READ, 8'h00, 11'd3, 1);
		queue_cmd(OP_READ, 8'h00, 11'd4, 0);
		queue_cmd(OP_READ, 8'h00, 11'd160, 0);
		queue_cmd(OP_READ, 8'h00, 11'd1024, 0);

		// random: screen-filling sequence first, behind a full drain
		drain_next = 1'b1;
		queue_screen_tail(1'b0, 1'b0);
		queue_cmd(OP_READ, 8'h00, 11'd1999, 0);
		queue_screen_tail(1'b1, 1'b0);
		while (cmd_q.size() < 380) begin
			kind = $urandom_range(0, 19);
			tight = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0)
				drain_next = 1'b1;
			if (kind < 8) begin
				repeat ($urandom_range(5, 40))
					queue_cmd(OP_PUT, pick_char(1'b1), 11'($urandom_range(0, 2047)),
						pick_gap(tight));
			end else if (kind < 10) begin
				repeat ($urandom_range(60, 100))
					queue_cmd(OP_PUT, pick_char(1'b0), '0, pick_gap(tight));
			end else if (kind < 14) begin
				repeat ($urandom_range(1, 8)) begin
					r = $urandom_range(0, 99);
					if (r < 60)
						queue_cmd(OP_READ, 8'($urandom_range(0, 255)),
							11'($urandom_range(0, CELLS - 1)), pick_gap(tight));
					else if (r < 85)
						queue_cmd(OP_READ, 8'($urandom_range(0, 255)),
							11'(plan_row * COLS + $urandom_range(0, COLS - 1)),
							pick_gap(tight));
					else
						queue_cmd(OP_READ, 8'($urandom_range(0, 255)),
							11'($urandom_range(CELLS, 2047)), pick_gap(tight));
				end
			end else if (kind < 16) begin
				repeat ($urandom_range(1, 25))
					queue_cmd(OP_PUT, NEWLINE_CODE, 11'($urandom_range(0, 2047)),
						pick_gap(tight));
			end else if (kind < 19) begin
				// noise: any field value at all
				repeat (10)
					queue_cmd(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)), pick_gap(tight));
			end else begin
				queue_screen_tail(($urandom_range(0, 1) == 1), tight);
			end
		end

		// reset with a real falling edge so the asynchronous reset takes hold
		#1;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start)
			@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (err_cnt == 0 && pending_reports.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// driver: hold a command until accepted, then load the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_cnt <= 0;
		end else begin
			if (start && !busy)
				pending_reports.push_back(advance_console(op_t'(operation), char_code,
					read_index));
			if (!start || !busy) begin
				if (idle_cnt != 0) begin
					idle_cnt <= idle_cnt - 1;
					start <= 1'b0;
				end else if (cmd_q.size() == 0) begin
					start <= 1'b0;
				end else if (cmd_q[0].drain && (pending_reports.size() != 0 || done)) begin
					// hold off until every beat in flight has come back
					start <= 1'b0;
				end else if (cmd_q[0].gap != 0) begin
					idle_cnt <= cmd_q[0].gap - 1;
					cmd_q[0].gap = 0;
					cmd_q[0].drain = 1'b0;
					start <= 1'b0;
				end else begin
					cmd = cmd_q.pop_front();
					start <= 1'b1;
					operation <= cmd.op;
					char_code <= cmd.code;
					read_index <= cmd.ridx;
				end
			end
		end
	end

	task automatic check_field(input string what, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_val,
				act_val);
		end
	endtask

	// monitor: every result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_reports.size() == 0) begin
				err_cnt++;
				$display("%0t: result beat with none expected, expected none actual idx %0h",
					$time, cell_index);
			end else begin
				want = pending_reports.pop_front();
				check_field("cursor_col", int'(want.col), int'(cursor_col));
				check_field("cursor_row", int'(want.row), int'(cursor_row));
				check_field("cell_index", int'(want.idx), int'(cell_index));
				check_field("cell_char", int'(want.ch), int'(cell_char));
				check_field("cell_attr", int'(want.attr), int'(cell_attr));
				check_field("screen_cleared", int'(want.clr), int'(screen_cleared));
			end
		end
	end

endmodule

@@ text_console_char_writer_core.f @@
+incdir+src
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_char_writer_core.sv
tb/sv/tb.sv
